/* rtl/mha_pkg.sv */
// Shared types, register map and constants for the machine health alarm block.
`default_nettype none

package mha_pkg;

  typedef enum logic [2:0] {
    ST_NOMINAL    = 3'd0,
    ST_VIB_WARN   = 3'd1,
    ST_THERM_WARN = 3'd2,
    ST_BREACH     = 3'd3,
    ST_CRIT       = 3'd4
  } alarm_state_t;

  typedef enum logic [2:0] {
    REG_VIB_WARN   = 3'd0,
    REG_VIB_CRIT   = 3'd1,
    REG_TEMP_WARN  = 3'd2,
    REG_TEMP_CRIT  = 3'd3,
    REG_GUARD_MIN  = 3'd4,
    REG_GUARD_MAX  = 3'd5,
    REG_CLEAR_HOLD = 3'd6
  } reg_idx_t;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // LED vector is {red, amber, green}
  localparam logic [2:0] LED_GREEN = 3'b001;
  localparam logic [2:0] LED_AMBER = 3'b010;
  localparam logic [2:0] LED_RED   = 3'b100;
  localparam logic [2:0] LED_ALL   = 3'b111;

  localparam logic [31:0] FLASH_MS   = 32'd250;
  localparam logic [8:0]  SWEEP_MAX  = 9'd180;
  localparam logic [8:0]  SWEEP_STEP = 9'd5;

  localparam logic [7:0] SERVO_NOMINAL = 8'd0;
  localparam logic [7:0] SERVO_VIB     = 8'd45;
  localparam logic [7:0] SERVO_THERM   = 8'd90;
  localparam logic [7:0] SERVO_BREACH  = 8'd180;

  localparam logic [15:0]        VIB_WARN_RST   = 16'd500;
  localparam logic [15:0]        VIB_CRIT_RST   = 16'd1000;
  localparam logic signed [15:0] TEMP_WARN_RST  = 16'sd600;
  localparam logic signed [15:0] TEMP_CRIT_RST  = 16'sd800;
  localparam logic [15:0]        GUARD_MIN_RST  = 16'd20;
  localparam logic [15:0]        GUARD_MAX_RST  = 16'd200;
  localparam logic [31:0]        CLEAR_HOLD_RST = 32'd3000;

  typedef struct packed {
    logic [15:0]        vib_wlvl;
    logic [15:0]        vib_clvl;
    logic signed [15:0] tmp_wlvl;
    logic signed [15:0] tmp_clvl;
    logic [15:0]        guard_min;
    logic [15:0]        guard_max;
    logic [31:0]        clear_hold;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic [15:0]        vib_rms;
    logic               temp_valid;
    logic signed [15:0] temp_dc;
    logic               dist_valid;
    logic [15:0]        dist_mm;
  } item_t;

  typedef struct packed {
    alarm_state_t state;
    logic [31:0]  clear_start;
    logic [31:0]  flash_start;
    logic [7:0]   sweep_angle;
    logic         sweep_falling;
    logic [2:0]   leds;
    logic [7:0]   servo_hold;
  } alarm_ctx_t;

endpackage

`default_nettype wire

/* rtl/mha_eval.sv */
// Threshold checks and alarm state update for one item.
`default_nettype none

module mha_eval (
  input  mha_pkg::cfg_t       cfg,
  input  mha_pkg::item_t      item,
  input  mha_pkg::alarm_ctx_t ctx,
  output mha_pkg::alarm_ctx_t ctx_nxt,
  output logic                entered
);

  logic        vib_w;
  logic        vib_c;
  logic        tmp_w;
  logic        tmp_c;
  logic        guard_out;
  logic        go_crit;
  logic        crit_entry;
  logic [31:0] flash_ref;
  logic [31:0] clear_ref;
  logic [8:0]  sweep_cur;
  logic        falling_cur;
  logic [8:0]  sweep_up;

  always_comb begin
    vib_w     = item.vib_rms >= cfg.vib_wlvl;
    vib_c     = item.vib_rms >= cfg.vib_clvl;
    tmp_w     = item.temp_valid && ($signed(item.temp_dc) >= $signed(cfg.tmp_wlvl));
    tmp_c     = item.temp_valid && ($signed(item.temp_dc) >= $signed(cfg.tmp_clvl));
    guard_out = item.dist_valid &&
                ((item.dist_mm < cfg.guard_min) || (item.dist_mm > cfg.guard_max));
    // a critical reading, or two or more warnings, escalate to critical
    go_crit   = vib_c || tmp_c || (vib_w && tmp_w) ||
                (vib_w && guard_out) || (tmp_w && guard_out);
    crit_entry = ctx.state != mha_pkg::ST_CRIT;
  end

  always_comb begin
    flash_ref   = crit_entry ? item.now_ms : ctx.flash_start;
    sweep_cur   = crit_entry ? 9'd0 : {1'b0, ctx.sweep_angle};
    falling_cur = crit_entry ? 1'b0 : ctx.sweep_falling;
    sweep_up    = sweep_cur + mha_pkg::SWEEP_STEP;
    // zero stored tick reads as timer not started
    clear_ref   = (ctx.clear_start == 32'd0) ? item.now_ms : ctx.clear_start;
  end

  always_comb begin
    ctx_nxt = ctx;
    entered = 1'b0;
    priority if (go_crit) begin
      ctx_nxt.state         = mha_pkg::ST_CRIT;
      entered               = crit_entry;
      ctx_nxt.flash_start   = flash_ref;
      ctx_nxt.sweep_angle   = sweep_cur[7:0];
      ctx_nxt.sweep_falling = falling_cur;
      if ((item.now_ms - flash_ref) >= mha_pkg::FLASH_MS) begin
        ctx_nxt.leds        = ctx.leds ^ mha_pkg::LED_ALL;
        ctx_nxt.flash_start = item.now_ms;
      end
      if (!falling_cur) begin
        if (sweep_up >= mha_pkg::SWEEP_MAX) begin
          ctx_nxt.sweep_angle   = mha_pkg::SWEEP_MAX[7:0];
          ctx_nxt.sweep_falling = 1'b1;
        end else begin
          ctx_nxt.sweep_angle = sweep_up[7:0];
        end
      end else if (sweep_cur >= mha_pkg::SWEEP_STEP) begin
        ctx_nxt.sweep_angle = 8'(sweep_cur - mha_pkg::SWEEP_STEP);
      end else begin
        ctx_nxt.sweep_angle   = 8'd0;
        ctx_nxt.sweep_falling = 1'b0;
      end
      ctx_nxt.servo_hold  = ctx_nxt.sweep_angle;
      ctx_nxt.clear_start = item.now_ms;
    end else if (guard_out) begin
      if (ctx.state != mha_pkg::ST_BREACH) begin
        ctx_nxt.state      = mha_pkg::ST_BREACH;
        ctx_nxt.leds       = mha_pkg::LED_RED;
        ctx_nxt.servo_hold = mha_pkg::SERVO_BREACH;
        entered            = 1'b1;
      end
      ctx_nxt.clear_start = item.now_ms;
    end else if (tmp_w) begin
      if (ctx.state != mha_pkg::ST_THERM_WARN) begin
        ctx_nxt.state      = mha_pkg::ST_THERM_WARN;
        ctx_nxt.leds       = mha_pkg::LED_AMBER;
        ctx_nxt.servo_hold = mha_pkg::SERVO_THERM;
        entered            = 1'b1;
      end
      ctx_nxt.clear_start = item.now_ms;
    end else if (vib_w) begin
      if (ctx.state != mha_pkg::ST_VIB_WARN) begin
        ctx_nxt.state      = mha_pkg::ST_VIB_WARN;
        ctx_nxt.leds       = mha_pkg::LED_AMBER;
        ctx_nxt.servo_hold = mha_pkg::SERVO_VIB;
        entered            = 1'b1;
      end
      ctx_nxt.clear_start = item.now_ms;
    end else if (ctx.state != mha_pkg::ST_NOMINAL) begin
      ctx_nxt.clear_start = clear_ref;
      if ((item.now_ms - clear_ref) >= cfg.clear_hold) begin
        ctx_nxt.state      = mha_pkg::ST_NOMINAL;
        ctx_nxt.leds       = mha_pkg::LED_GREEN;
        ctx_nxt.servo_hold = mha_pkg::SERVO_NOMINAL;
        entered            = 1'b1;
      end
    end else begin
      // nominal and all clear: hold
    end
  end

endmodule

`default_nettype wire

/* rtl/machine_health_alarm_fsm_core.sv */
// Machine health alarm core: input register, alarm update and result register.
//
// Usage:
//   Input channel in_*: one monitoring update per item (timestamp, vibration,
//   temperature with valid flag, guard distance with valid flag).
//   Result channel out_*: one item per input item, in order, carrying the
//   alarm state, the three LED levels, the servo angle and a state-entered flag.
//   Both channels use valid/stall; an item moves on an edge with valid high
//   and stall low.
//   Thresholds and the clear hold time sit in APB registers at 4*index;
//   write them only while no item is in flight.
// Registers and throughput:
//   An accepted item lands in the input register; once the result register
//   can advance, its result is loaded there and out_valid rises. One item per
//   cycle is sustained while the receiver does not stall. The alarm state
//   update is one pass of compare and select logic between the two.
// Reset and stall:
//   Reset empties both registers, sets the thresholds to their defaults and
//   puts the alarm in nominal with green on and the servo at zero. When the
//   receiver stalls, the result holds; an empty input register still takes
//   one item, and in_stall is high while both registers are full.
`default_nettype none

module machine_health_alarm_fsm_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [31:0]                  in_now_ms,
  input  wire logic [15:0]                  in_vib_rms,
  input  wire logic                         in_temp_valid,
  input  wire logic signed [15:0]           in_temp_dc,
  input  wire logic                         in_dist_valid,
  input  wire logic [15:0]                  in_dist_mm,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [2:0]                        out_alarm_state,
  output logic                              out_green_on,
  output logic                              out_amber_on,
  output logic                              out_red_on,
  output logic [7:0]                        out_servo_angle,
  output logic                              out_state_entered,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mha_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [mha_pkg::DATA_W-1:0]   pwdata,
  output logic [mha_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  mha_pkg::cfg_t       cfg_r;
  mha_pkg::item_t      item_r;
  logic                item_valid_r;
  mha_pkg::alarm_ctx_t ctx_r;
  mha_pkg::alarm_ctx_t ctx_nxt;
  logic                entered;
  logic                out_valid_r;
  logic [2:0]          out_state_r;
  logic [2:0]          out_leds_r;
  logic [7:0]          out_servo_r;
  logic                out_entered_r;
  logic                advance;
  logic                item_load;
  logic                cfg_we;
  mha_pkg::reg_idx_t   reg_idx;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_idx = mha_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.vib_wlvl   <= mha_pkg::VIB_WARN_RST;
      cfg_r.vib_clvl   <= mha_pkg::VIB_CRIT_RST;
      cfg_r.tmp_wlvl   <= mha_pkg::TEMP_WARN_RST;
      cfg_r.tmp_clvl   <= mha_pkg::TEMP_CRIT_RST;
      cfg_r.guard_min  <= mha_pkg::GUARD_MIN_RST;
      cfg_r.guard_max  <= mha_pkg::GUARD_MAX_RST;
      cfg_r.clear_hold <= mha_pkg::CLEAR_HOLD_RST;
    end else if (cfg_we) begin
      case (reg_idx)
        mha_pkg::REG_VIB_WARN:   cfg_r.vib_wlvl   <= pwdata[15:0];
        mha_pkg::REG_VIB_CRIT:   cfg_r.vib_clvl   <= pwdata[15:0];
        mha_pkg::REG_TEMP_WARN:  cfg_r.tmp_wlvl   <= pwdata[15:0];
        mha_pkg::REG_TEMP_CRIT:  cfg_r.tmp_clvl   <= pwdata[15:0];
        mha_pkg::REG_GUARD_MIN:  cfg_r.guard_min  <= pwdata[15:0];
        mha_pkg::REG_GUARD_MAX:  cfg_r.guard_max  <= pwdata[15:0];
        mha_pkg::REG_CLEAR_HOLD: cfg_r.clear_hold <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mha_pkg::REG_VIB_WARN:   prdata = {16'd0, cfg_r.vib_wlvl};
      mha_pkg::REG_VIB_CRIT:   prdata = {16'd0, cfg_r.vib_clvl};
      mha_pkg::REG_TEMP_WARN:  prdata = {16'd0, cfg_r.tmp_wlvl};
      mha_pkg::REG_TEMP_CRIT:  prdata = {16'd0, cfg_r.tmp_clvl};
      mha_pkg::REG_GUARD_MIN:  prdata = {16'd0, cfg_r.guard_min};
      mha_pkg::REG_GUARD_MAX:  prdata = {16'd0, cfg_r.guard_max};
      mha_pkg::REG_CLEAR_HOLD: prdata = cfg_r.clear_hold;
      default:                 prdata = '0;
    endcase
  end

  // ---------------- datapath handshake ----------------
  assign advance   = !out_valid_r || !out_stall;
  assign item_load = !item_valid_r || advance;
  assign in_stall  = !item_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (item_load) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_load && in_valid) begin
      item_r.now_ms     <= in_now_ms;
      item_r.vib_rms    <= in_vib_rms;
      item_r.temp_valid <= in_temp_valid;
      item_r.temp_dc    <= in_temp_dc;
      item_r.dist_valid <= in_dist_valid;
      item_r.dist_mm    <= in_dist_mm;
    end
  end

  mha_eval u_eval (
    .cfg     (cfg_r),
    .item    (item_r),
    .ctx     (ctx_r),
    .ctx_nxt (ctx_nxt),
    .entered (entered)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r.state         <= mha_pkg::ST_NOMINAL;
      ctx_r.clear_start   <= 32'd0;
      ctx_r.flash_start   <= 32'd0;
      ctx_r.sweep_angle   <= 8'd0;
      ctx_r.sweep_falling <= 1'b0;
      ctx_r.leds          <= mha_pkg::LED_GREEN;
      ctx_r.servo_hold    <= mha_pkg::SERVO_NOMINAL;
    end else if (advance && item_valid_r) begin
      ctx_r <= ctx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid_r) begin
      out_state_r   <= ctx_nxt.state;
      out_leds_r    <= ctx_nxt.leds;
      out_servo_r   <= ctx_nxt.servo_hold;
      out_entered_r <= entered;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_alarm_state   = out_state_r;
  assign out_green_on      = out_leds_r[0];
  assign out_amber_on      = out_leds_r[1];
  assign out_red_on        = out_leds_r[2];
  assign out_servo_angle   = out_servo_r;
  assign out_state_entered = out_entered_r;

  // ---------------- assertions ----------------
  a_item_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> item_valid_r)
    else $error("accepted item did not reach the input register");

  a_ctx_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(advance && item_valid_r) |=> $stable(ctx_r))
    else $error("alarm state changed without an item");

  a_nominal_outputs: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_state_r == mha_pkg::ST_NOMINAL) |->
      (out_leds_r == mha_pkg::LED_GREEN && out_servo_r == mha_pkg::SERVO_NOMINAL))
    else $error("nominal result without green-only LEDs and parked servo");

  a_breach_outputs: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_state_r == mha_pkg::ST_BREACH) |->
      (out_leds_r == mha_pkg::LED_RED && out_servo_r == mha_pkg::SERVO_BREACH))
    else $error("breach result without red-only LEDs and full servo");

  a_servo_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_servo_r <= mha_pkg::SERVO_BREACH))
    else $error("servo angle beyond sweep limit");

endmodule

`default_nettype wire

/* sim/mha_alarm_checker.sv */
// Alarm checker: snoops the register port and both channels, predicts each result, compares.
`timescale 1ns / 100ps

module mha_alarm_checker (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic                       in_stall,
  input  wire logic [31:0]                in_now_ms,
  input  wire logic [15:0]                in_vib_rms,
  input  wire logic                       in_temp_valid,
  input  wire logic signed [15:0]         in_temp_dc,
  input  wire logic                       in_dist_valid,
  input  wire logic [15:0]                in_dist_mm,
  input  wire logic                       out_valid,
  input  wire logic                       out_stall,
  input  wire logic [2:0]                 out_alarm_state,
  input  wire logic                       out_green_on,
  input  wire logic                       out_amber_on,
  input  wire logic                       out_red_on,
  input  wire logic [7:0]                 out_servo_angle,
  input  wire logic                       out_state_entered,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mha_pkg::ADDR_W-1:0] paddr,
  input  wire logic [mha_pkg::DATA_W-1:0] pwdata,
  input  wire logic                       pready,
  output int                              due_count,
  output int                              mismatch_count
);
  import mha_pkg::*;

  typedef struct packed {
    alarm_state_t state;
    logic [2:0]   leds;
    logic [7:0]   servo;
    logic         entered;
  } alarm_result_t;

  cfg_t         thr;
  alarm_state_t alarm_st;
  logic [31:0]  clear_since;
  logic [31:0]  flash_since;
  logic [7:0]   sweep_pos;
  logic         sweep_down;
  logic [2:0]   led_now;
  logic [7:0]   servo_now;

  alarm_result_t alarms_due_q[$];
  int            errs = 0;

  function automatic void reset_alarm_model();
    thr.vib_wlvl   = VIB_WARN_RST;
    thr.vib_clvl   = VIB_CRIT_RST;
    thr.tmp_wlvl   = TEMP_WARN_RST;
    thr.tmp_clvl   = TEMP_CRIT_RST;
    thr.guard_min  = GUARD_MIN_RST;
    thr.guard_max  = GUARD_MAX_RST;
    thr.clear_hold = CLEAR_HOLD_RST;
    alarm_st    = ST_NOMINAL;
    clear_since = '0;
    flash_since = '0;
    sweep_pos   = '0;
    sweep_down  = 1'b0;
    led_now     = LED_GREEN;
    servo_now   = SERVO_NOMINAL;
  endfunction

  function automatic void enter_state(alarm_state_t s, logic [2:0] leds, logic [7:0] servo);
    alarm_st  = s;
    led_now   = leds;
    servo_now = servo;
  endfunction

  function automatic alarm_result_t predict_alarm(item_t u);
    logic          vw, vc, tw, tc, gd, entered;
    int            nwarn;
    alarm_result_t r;
    vw = u.vib_rms >= thr.vib_wlvl;
    vc = u.vib_rms >= thr.vib_clvl;
    tw = u.temp_valid && ($signed(u.temp_dc) >= $signed(thr.tmp_wlvl));
    tc = u.temp_valid && ($signed(u.temp_dc) >= $signed(thr.tmp_clvl));
    gd = u.dist_valid && (u.dist_mm < thr.guard_min || u.dist_mm > thr.guard_max);
    nwarn = int'(vw) + int'(tw) + int'(gd);
    entered = 1'b0;
    if (vc || tc || nwarn >= 2) begin
      if (alarm_st != ST_CRIT) begin
        alarm_st    = ST_CRIT;
        flash_since = u.now_ms;
        sweep_pos   = '0;
        sweep_down  = 1'b0;
        entered     = 1'b1;
      end
      if (u.now_ms - flash_since >= FLASH_MS) begin
        led_now     = led_now ^ LED_ALL;
        flash_since = u.now_ms;
      end
      if (!sweep_down) begin
        if (int'(sweep_pos) + int'(SWEEP_STEP) >= int'(SWEEP_MAX)) begin
          sweep_pos  = 8'(SWEEP_MAX);
          sweep_down = 1'b1;
        end else begin
          sweep_pos = sweep_pos + 8'(SWEEP_STEP);
        end
      end else if (int'(sweep_pos) >= int'(SWEEP_STEP)) begin
        sweep_pos = sweep_pos - 8'(SWEEP_STEP);
      end else begin
        sweep_pos  = '0;
        sweep_down = 1'b0;
      end
      servo_now   = sweep_pos;
      clear_since = u.now_ms;
    end else if (gd) begin
      if (alarm_st != ST_BREACH) begin
        enter_state(ST_BREACH, LED_RED, SERVO_BREACH);
        entered = 1'b1;
      end
      clear_since = u.now_ms;
    end else if (tw) begin
      if (alarm_st != ST_THERM_WARN) begin
        enter_state(ST_THERM_WARN, LED_AMBER, SERVO_THERM);
        entered = 1'b1;
      end
      clear_since = u.now_ms;
    end else if (vw) begin
      if (alarm_st != ST_VIB_WARN) begin
        enter_state(ST_VIB_WARN, LED_AMBER, SERVO_VIB);
        entered = 1'b1;
      end
      clear_since = u.now_ms;
    end else if (alarm_st != ST_NOMINAL) begin
      // a stored tick of zero reads as a hold that has not started
      if (clear_since == '0) clear_since = u.now_ms;
      if (u.now_ms - clear_since >= thr.clear_hold) begin
        enter_state(ST_NOMINAL, LED_GREEN, SERVO_NOMINAL);
        entered = 1'b1;
      end
    end
    r.state   = alarm_st;
    r.leds    = led_now;
    r.servo   = servo_now;
    r.entered = entered;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v) begin
      errs++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : watch
    alarm_result_t want;
    item_t         u;
    if (!rst_n) begin
      reset_alarm_model();
      alarms_due_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_VIB_WARN:   thr.vib_wlvl   = pwdata[15:0];
          REG_VIB_CRIT:   thr.vib_clvl   = pwdata[15:0];
          REG_TEMP_WARN:  thr.tmp_wlvl   = pwdata[15:0];
          REG_TEMP_CRIT:  thr.tmp_clvl   = pwdata[15:0];
          REG_GUARD_MIN:  thr.guard_min  = pwdata[15:0];
          REG_GUARD_MAX:  thr.guard_max  = pwdata[15:0];
          REG_CLEAR_HOLD: thr.clear_hold = pwdata[31:0];
          default: ;
        endcase
      end
      // compare before queuing, so a result never matches an item taken at the same edge
      if (out_valid && !out_stall) begin
        if (alarms_due_q.size() == 0) begin
          errs++;
          $display("%0t: result with no item pending, state %0d servo %0d", $time,
                   out_alarm_state, out_servo_angle);
        end else begin
          want = alarms_due_q.pop_front();
          check_field("alarm_state", 8'(want.state), 8'(out_alarm_state));
          check_field("green_on", 8'(want.leds[0]), 8'(out_green_on));
          check_field("amber_on", 8'(want.leds[1]), 8'(out_amber_on));
          check_field("red_on", 8'(want.leds[2]), 8'(out_red_on));
          check_field("servo_angle", want.servo, out_servo_angle);
          check_field("state_entered", 8'(want.entered), 8'(out_state_entered));
        end
      end
      if (in_valid && !in_stall) begin
        u.now_ms     = in_now_ms;
        u.vib_rms    = in_vib_rms;
        u.temp_valid = in_temp_valid;
        u.temp_dc    = in_temp_dc;
        u.dist_valid = in_dist_valid;
        u.dist_mm    = in_dist_mm;
        alarms_due_q.push_back(predict_alarm(u));
      end
    end
    due_count      <= alarms_due_q.size();
    mismatch_count <= errs;
  end

endmodule

/* sim/tb.sv */
// Testbench top: drives updates and threshold settings into the alarm core and reports the verdict.
`timescale 1ns / 100ps

module tb;
  import mha_pkg::*;

  typedef enum logic [1:0] {MODE_QUIET, MODE_MIXED, MODE_CRIT, MODE_NOISE} stim_mode_t;
  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BLOCKS} stall_mode_t;

  localparam logic [2:0] REG_SPARE   = 3'd7;
  localparam int         CYCLE_LIMIT = 300000;
  localparam int         PHASES      = 7;
  localparam int         PHASE_ITEMS = 150;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid      = 1'b0;
  logic              in_stall;
  logic [31:0]       in_now_ms     = '0;
  logic [15:0]       in_vib_rms    = '0;
  logic              in_temp_valid = 1'b0;
  logic signed [15:0] in_temp_dc   = '0;
  logic              in_dist_valid = 1'b0;
  logic [15:0]       in_dist_mm    = '0;
  logic              out_valid;
  logic              out_stall     = 1'b0;
  logic [2:0]        out_alarm_state;
  logic              out_green_on, out_amber_on, out_red_on;
  logic [7:0]        out_servo_angle;
  logic              out_state_entered;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int due_count, mismatch_count;

  cfg_t        cfg_now;
  logic [31:0] now_t      = '0;
  int          burst_left = 10;
  logic        valid_up   = 1'b0;
  int          cycle_cnt  = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;

  machine_health_alarm_fsm_core i_dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_now_ms, .in_vib_rms, .in_temp_valid, .in_temp_dc,
    .in_dist_valid, .in_dist_mm,
    .out_valid, .out_stall, .out_alarm_state, .out_green_on, .out_amber_on,
    .out_red_on, .out_servo_angle, .out_state_entered,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  mha_alarm_checker i_check (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_now_ms, .in_vib_rms, .in_temp_valid, .in_temp_dc,
    .in_dist_valid, .in_dist_mm,
    .out_valid, .out_stall, .out_alarm_state, .out_green_on, .out_amber_on,
    .out_red_on, .out_servo_angle, .out_state_entered,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .due_count, .mismatch_count
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // result-side back-pressure, one pattern per segment
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(10, 150);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
      default:     out_stall <= (stall_left[3:0] < 4'd12);
    endcase
  end

  function automatic logic [ADDR_W-1:0] reg_addr(logic [2:0] idx);
    return {idx, 2'b00};
  endfunction

  function automatic logic [15:0] clamp_u16(int v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hFFFF;
    return 16'(v);
  endfunction

  function automatic logic [15:0] clamp_s16(int v);
    if (v < -32768) return 16'h8000;
    if (v > 32767) return 16'h7FFF;
    return 16'(v);
  endfunction

  function automatic item_t mk(logic [31:0] t, logic [15:0] v, logic tv, logic [15:0] tc,
                               logic dv, logic [15:0] d);
    item_t u;
    u.now_ms     = t;
    u.vib_rms    = v;
    u.temp_valid = tv;
    u.temp_dc    = tc;
    u.dist_valid = dv;
    u.dist_mm    = d;
    return u;
  endfunction

  task automatic write_reg(logic [ADDR_W-1:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_thresholds(cfg_t c);
    // junk in the unused upper bits must be dropped
    write_reg(reg_addr(REG_VIB_WARN), {16'($urandom), c.vib_wlvl});
    write_reg(reg_addr(REG_VIB_CRIT), {16'($urandom), c.vib_clvl});
    write_reg(reg_addr(REG_TEMP_WARN), {16'($urandom), c.tmp_wlvl});
    write_reg(reg_addr(REG_TEMP_CRIT), {16'($urandom), c.tmp_clvl});
    write_reg(reg_addr(REG_GUARD_MIN), {16'($urandom), c.guard_min});
    write_reg(reg_addr(REG_GUARD_MAX), {16'($urandom), c.guard_max});
    write_reg(reg_addr(REG_CLEAR_HOLD), c.clear_hold);
    cfg_now = c;
  endtask

  task automatic send_update(item_t u);
    int gap;
    in_valid      <= 1'b1;
    in_now_ms     <= u.now_ms;
    in_vib_rms    <= u.vib_rms;
    in_temp_valid <= u.temp_valid;
    in_temp_dc    <= u.temp_dc;
    in_dist_valid <= u.dist_valid;
    in_dist_mm    <= u.dist_mm;
    valid_up = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        valid_up = 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 40);
    end
  endtask

  // hold the sender until every pending result is back
  task automatic drain();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
    end
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [31:0] tick_clock();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) now_t = now_t + $urandom_range(0, 120);
    else if (r < 88) now_t = now_t + $urandom_range(120, 400);
    else if (r < 95) now_t = now_t + $urandom_range(0, 4000);
    else if (r < 97) now_t = $urandom;
    else if (r < 98) now_t = 32'hFFFF_FFFF - $urandom_range(0, 500);
    else if (r < 99) now_t = now_t - $urandom_range(0, 50);
    else now_t = '0;
    return now_t;
  endfunction

  function automatic logic [15:0] pick_vib(stim_mode_t m);
    int lim;
    lim = (cfg_now.vib_wlvl < cfg_now.vib_clvl) ? int'(cfg_now.vib_wlvl)
                                                : int'(cfg_now.vib_clvl);
    if (m == MODE_NOISE) return 16'($urandom);
    if (m != MODE_QUIET) begin
      case ($urandom_range(0, 9))
        4, 5, 6: return clamp_u16(int'(cfg_now.vib_wlvl) + int'($urandom_range(0, 4)) - 2);
        7, 8:    return clamp_u16(int'(cfg_now.vib_clvl) + int'($urandom_range(0, 4)) - 2);
        9:       return 16'($urandom);
        default: ;
      endcase
    end
    if (lim == 0) return 16'd0;
    if ($urandom_range(0, 1)) return 16'(lim - 1);
    return 16'($urandom_range(0, lim - 1));
  endfunction

  function automatic logic [16:0] pick_temp(stim_mode_t m);
    int tlim, span, v;
    tlim = ($signed(cfg_now.tmp_wlvl) < $signed(cfg_now.tmp_clvl))
           ? int'($signed(cfg_now.tmp_wlvl)) : int'($signed(cfg_now.tmp_clvl));
    if (m == MODE_NOISE) return 17'($urandom);
    if (m != MODE_QUIET) begin
      case ($urandom_range(0, 9))
        4, 5, 6: return {1'b1, clamp_s16(int'($signed(cfg_now.tmp_wlvl))
                                         + int'($urandom_range(0, 4)) - 2)};
        7, 8:    return {1'b1, clamp_s16(int'($signed(cfg_now.tmp_clvl))
                                         + int'($urandom_range(0, 4)) - 2)};
        9:       return 17'($urandom);
        default: ;
      endcase
    end
    if (tlim == -32768 || $urandom_range(0, 2) == 0) return {1'b0, 16'($urandom)};
    span = tlim - 1 + 32768;
    if ($urandom_range(0, 1)) v = tlim - 1 - int'($urandom_range(0, (span < 5) ? span : 5));
    else v = -32768 + int'($urandom_range(0, span));
    return {1'b1, 16'(v)};
  endfunction

  function automatic logic [16:0] pick_dist(stim_mode_t m);
    logic [15:0] d;
    if (m == MODE_NOISE) return 17'($urandom);
    if (m != MODE_QUIET) begin
      case ($urandom_range(0, 9))
        5, 6:    return {1'b1, clamp_u16(int'(cfg_now.guard_min) + int'($urandom_range(0, 4)) - 2)};
        7, 8:    return {1'b1, clamp_u16(int'(cfg_now.guard_max) + int'($urandom_range(0, 4)) - 2)};
        9:       return 17'($urandom);
        default: ;
      endcase
    end
    if (cfg_now.guard_min > cfg_now.guard_max || $urandom_range(0, 2) == 0)
      return {1'b0, 16'($urandom)};
    case ($urandom_range(0, 2))
      0:       d = cfg_now.guard_min;
      1:       d = cfg_now.guard_max;
      default: d = cfg_now.guard_min + 16'($urandom_range(0, cfg_now.guard_max - cfg_now.guard_min));
    endcase
    return {1'b1, d};
  endfunction

  function automatic item_t shape_update(stim_mode_t m);
    item_t u;
    u.now_ms = tick_clock();
    u.vib_rms = pick_vib(m);
    {u.temp_valid, u.temp_dc} = pick_temp(m);
    {u.dist_valid, u.dist_mm} = pick_dist(m);
    // keep one reading past its critical level
    if (m == MODE_CRIT) begin
      if ($urandom_range(0, 1)) begin
        u.vib_rms = clamp_u16(int'(cfg_now.vib_clvl) + int'($urandom_range(0, 40)));
      end else begin
        u.temp_valid = 1'b1;
        u.temp_dc = clamp_s16(int'($signed(cfg_now.tmp_clvl)) + int'($urandom_range(0, 40)));
      end
    end
    return u;
  endfunction

  function automatic cfg_t random_thresholds();
    cfg_t c;
    logic [15:0] sw;
    c.vib_wlvl  = 16'($urandom_range(50, 3000));
    c.vib_clvl  = clamp_u16(int'(c.vib_wlvl) + int'($urandom_range(0, 3000)));
    c.tmp_wlvl  = 16'(int'($urandom_range(0, 1400)) - 500);
    c.tmp_clvl  = clamp_s16(int'($signed(c.tmp_wlvl)) + int'($urandom_range(0, 600)));
    c.guard_min = 16'($urandom_range(0, 100));
    c.guard_max = c.guard_min + 16'($urandom_range(0, 500));
    if ($urandom_range(0, 3) == 0) begin
      sw = c.vib_wlvl; c.vib_wlvl = c.vib_clvl; c.vib_clvl = sw;
    end
    if ($urandom_range(0, 3) == 0) begin
      sw = c.tmp_wlvl; c.tmp_wlvl = c.tmp_clvl; c.tmp_clvl = sw;
    end
    if ($urandom_range(0, 4) == 0) begin
      sw = c.guard_min; c.guard_min = c.guard_max; c.guard_max = sw;
    end
    case ($urandom_range(0, 5))
      0:       c.clear_hold = 32'd0;
      1:       c.clear_hold = 32'd1;
      2, 3:    c.clear_hold = $urandom_range(1, 1500);
      default: c.clear_hold = $urandom_range(1500, 5000);
    endcase
    return c;
  endfunction

  task automatic run_updates(int count);
    stim_mode_t mode;
    int         run_left;
    mode = MODE_MIXED;
    run_left = 0;
    repeat (count) begin
      if (run_left == 0) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6: mode = MODE_QUIET;
          7, 8, 9, 10, 11, 12: mode = MODE_MIXED;
          13, 14, 15, 16:      mode = MODE_CRIT;
          default:             mode = MODE_NOISE;
        endcase
        run_left = (mode == MODE_CRIT) ? $urandom_range(5, 90) : $urandom_range(3, 40);
      end
      run_left--;
      send_update(shape_update(mode));
    end
  endtask

  initial begin
    cfg_t c;
    cfg_now.vib_wlvl   = VIB_WARN_RST;
    cfg_now.vib_clvl   = VIB_CRIT_RST;
    cfg_now.tmp_wlvl   = TEMP_WARN_RST;
    cfg_now.tmp_clvl   = TEMP_CRIT_RST;
    cfg_now.guard_min  = GUARD_MIN_RST;
    cfg_now.guard_max  = GUARD_MAX_RST;
    cfg_now.clear_hold = CLEAR_HOLD_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed updates on the reset thresholds
    send_update(mk(32'd100, 16'd0, 1'b0, 16'h7FFF, 1'b0, 16'd0));
    send_update(mk(32'd200, 16'd500, 1'b0, 16'h7FFF, 1'b0, 16'd0));
    send_update(mk(32'd300, 16'd499, 1'b1, 16'd600, 1'b1, 16'd20));
    send_update(mk(32'd400, 16'd0, 1'b1, 16'h8000, 1'b1, 16'd19));
    send_update(mk(32'd500, 16'd0, 1'b1, 16'd599, 1'b1, 16'd201));
    send_update(mk(32'd600, 16'd499, 1'b1, 16'd599, 1'b1, 16'd200));
    send_update(mk(32'd3499, 16'd0, 1'b0, 16'd0, 1'b0, 16'd0));
    send_update(mk(32'd3500, 16'd0, 1'b0, 16'd0, 1'b0, 16'd0));
    send_update(mk(32'd3600, 16'd1000, 1'b0, 16'd0, 1'b0, 16'd0));
    send_update(mk(32'd3849, 16'd500, 1'b1, 16'd600, 1'b0, 16'd0));
    send_update(mk(32'd3850, 16'd0, 1'b1, 16'd800, 1'b0, 16'd0));
    send_update(mk(32'd3900, 16'd0, 1'b1, 16'd600, 1'b1, 16'hFFFF));
    send_update(mk(32'd4000, 16'hFFFF, 1'b1, 16'h7FFF, 1'b1, 16'hFFFF));
    // a zero tick stored by an active reading counts as a hold not yet started
    send_update(mk(32'd0, 16'd500, 1'b0, 16'd0, 1'b0, 16'd0));
    send_update(mk(32'd10, 16'd0, 1'b0, 16'd0, 1'b0, 16'd0));
    send_update(mk(32'd3009, 16'd0, 1'b0, 16'd0, 1'b0, 16'd0));
    send_update(mk(32'd3010, 16'd0, 1'b0, 16'd0, 1'b0, 16'd0));
    // clear hold across the tick wrap
    send_update(mk(32'hFFFF_FF00, 16'd0, 1'b0, 16'd0, 1'b1, 16'd5));
    send_update(mk(32'hFFFF_FF10, 16'd0, 1'b0, 16'd0, 1'b1, 16'd100));
    send_update(mk(32'hFFFF_FF00 + 32'd2999, 16'd0, 1'b0, 16'd0, 1'b0, 16'd0));
    send_update(mk(32'hFFFF_FF00 + 32'd3000, 16'd0, 1'b0, 16'd0, 1'b0, 16'd0));
    send_update(mk(32'hFFFF_FFFF, 16'hFFFF, 1'b1, 16'h8000, 1'b1, 16'hFFFF));
    now_t = 32'd5000;

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: c = cfg_now;
        1: begin
          c.vib_wlvl = 16'd0;  c.vib_clvl = 16'd0;
          c.tmp_wlvl = 16'h8000; c.tmp_clvl = 16'h8000;
          c.guard_min = 16'd0; c.guard_max = 16'd0;
          c.clear_hold = 32'd0;
        end
        2: begin
          c.vib_wlvl = 16'hFFFF; c.vib_clvl = 16'hFFFF;
          c.tmp_wlvl = 16'h7FFF; c.tmp_clvl = 16'h7FFF;
          c.guard_min = 16'hFFFF; c.guard_max = 16'hFFFF;
          c.clear_hold = 32'hFFFF_FFFF;
        end
        default: c = random_thresholds();
      endcase
      apply_thresholds(c);
      if (p == 3) write_reg(reg_addr(REG_SPARE), $urandom);
      run_updates(PHASE_ITEMS);
    end

    drain();
    if (mismatch_count == 0 && due_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
